FILE: src/csd_pkg.sv
// Shared types, command codes and outcome codes of the CAN servo command decoder.
package csd_pkg;

	// Default parameter values
	localparam int CommandBaseDef = 1280;
	localparam int SendBaseDef    = 600;
	localparam int DefaultNodeDef = 0;
	localparam int FracBitsDef    = 16;

	// Stream widths
	localparam int InDataW  = 56;
	localparam int OutDataW = 40;

	// Command codes
	localparam logic [7:0] CMD_NODE_ID  = 8'h01;
	localparam logic [7:0] CMD_WORD0    = 8'h02;
	localparam logic [7:0] CMD_WORD1    = 8'h03;
	localparam logic [7:0] CMD_WORD2    = 8'h04;
	localparam logic [7:0] CMD_ADC_LO   = 8'h05;
	localparam logic [7:0] CMD_ADC_HI   = 8'h06;
	localparam logic [7:0] CMD_ANG_LO   = 8'h07;
	localparam logic [7:0] CMD_ANG_HI   = 8'h08;
	localparam logic [7:0] CMD_WORD3    = 8'h09;
	localparam logic [7:0] CMD_WORD4    = 8'h10;
	localparam logic [7:0] CMD_WORD5    = 8'h11;
	localparam logic [7:0] CMD_WORD6    = 8'h12;
	localparam logic [7:0] CMD_BYTE7    = 8'h13;
	localparam logic [7:0] CMD_TARGET   = 8'h14;

	// Outcome codes
	localparam logic [2:0] OUT_IGNORED  = 3'd0;
	localparam logic [2:0] OUT_SETTING  = 3'd1;
	localparam logic [2:0] OUT_SETPOINT = 3'd2;
	localparam logic [2:0] OUT_SEND     = 3'd3;
	localparam logic [2:0] OUT_ZERO     = 3'd4;

	// Divider sizes: product magnitude and span magnitude
	localparam int DivNumW = 48;
	localparam int DivDenW = 32;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic latch;
		logic apply_dec;
		logic load_sub;
		logic load_mul;
		logic apply_zero;
		logic div_start;
		logic apply_map;
	} csd_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic is_map;
		logic span_zero;
		logic div_done;
	} csd_sts_t;

endpackage

FILE: src/can_servo_command_decoder.sv
// Top level of the CAN servo command decoder: controller plus datapath.
//
// Channel | Direction | Payload
// s_*     | in        | frame_id, command, payload_b1..payload_b4
// m_*     | out       | outcome, setpoint, send_code, commit_pending, node_address
//
// A frame that only decodes goes from the decode state straight to the result.
// A target-angle frame passes the decode, multiply, divider start, divide and finish states;
// a zero angle span ends it at the multiply state with the zero outcome.
// One request is in flight at a time; s_tready is low until the result is taken.
// The result holds while m_tready is low. Reset is asynchronous and active low.
module can_servo_command_decoder
	import csd_pkg::*;
#(
	parameter int COMMAND_BASE = CommandBaseDef,
	parameter int SEND_BASE    = SendBaseDef,
	parameter int DEFAULT_NODE = DefaultNodeDef,
	parameter int FRAC_BITS    = FracBitsDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// frame_id[10:0], command[18:11], payload_b1..b4[50:19], zero pad
	input  logic [InDataW-1:0]  s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// outcome[2:0], setpoint[18:3], send_code[26:19], commit_pending[27],
	// node_address[35:28], zero pad
	output logic [OutDataW-1:0] m_tdata
);

	csd_cmd_t    cmd;
	csd_sts_t    sts;
	logic [2:0]  outcome;
	logic [15:0] setpoint;
	logic [7:0]  send_code;
	logic        commit_pending;
	logic [7:0]  node_address;

	csd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	csd_dp #(
		.COMMAND_BASE (COMMAND_BASE),
		.SEND_BASE    (SEND_BASE),
		.DEFAULT_NODE (DEFAULT_NODE),
		.FRAC_BITS    (FRAC_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.frame_id       (s_tdata[10:0]),
		.command        (s_tdata[18:11]),
		.word           (s_tdata[50:19]),
		.outcome        (outcome),
		.setpoint       (setpoint),
		.send_code      (send_code),
		.commit_pending (commit_pending),
		.node_address   (node_address)
	);

	assign m_tdata = {4'b0, node_address, commit_pending, send_code, setpoint, outcome};

endmodule

FILE: src/csd_div.sv
// Iterative unsigned divider, two quotient bits per cycle.
module csd_div
	import csd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DivNumW-1:0] num,
	input  logic [DivDenW-1:0] den,
	output logic               done,
	output logic [DivNumW-1:0] quo
);

	localparam int Steps = DivNumW / 2;
	localparam int CntW  = $clog2(Steps + 1);

	logic [DivDenW-1:0] rem_q;
	logic [DivNumW-1:0] quo_q;
	logic [DivDenW-1:0] den_q;
	logic [CntW-1:0]    cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [DivDenW-1:0] rem_d;
	logic [DivNumW-1:0] quo_d;

	// Two restoring steps on the running remainder
	always_comb begin
		logic [DivDenW:0] r;
		rem_d = rem_q;
		quo_d = quo_q;
		for (int i = 0; i < 2; i++) begin
			r = {rem_d, quo_d[DivNumW-1]};
			if (r >= {1'b0, den_q}) begin
				r = r - {1'b0, den_q};
				quo_d = {quo_d[DivNumW-2:0], 1'b1};
			end else begin
				quo_d = {quo_d[DivNumW-2:0], 1'b0};
			end
			rem_d = r[DivDenW-1:0];
		end
	end

	// Sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(Steps);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= rem_d;
			quo_q <= quo_d;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

FILE: src/csd_dp.sv
// Datapath: stored settings, float conversion, setpoint mapping and result registers.
module csd_dp
	import csd_pkg::*;
#(
	parameter int COMMAND_BASE = CommandBaseDef,
	parameter int SEND_BASE    = SendBaseDef,
	parameter int DEFAULT_NODE = DefaultNodeDef,
	parameter int FRAC_BITS    = FracBitsDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  csd_cmd_t    cmd,
	output csd_sts_t    sts,
	input  logic [10:0] frame_id,
	input  logic [7:0]  command,
	input  logic [31:0] word,
	output logic [2:0]  outcome,
	output logic [15:0] setpoint,
	output logic [7:0]  send_code,
	output logic        commit_pending,
	output logic [7:0]  node_address
);

	localparam longint HiRaw = 64'sd180 * (64'sd1 <<< FRAC_BITS);
	localparam logic [31:0] AngHiRst = (HiRaw > 64'sd2147483647) ? 32'h7FFF_FFFF : 32'(HiRaw);

	logic [10:0] fid_q;
	logic [7:0]  cmd_q;
	logic [31:0] word_q;
	logic [7:0]  node_q;
	logic [15:0] alo_q, ahi_q, setp_q;
	logic [31:0] anglo_q, anghi_q;
	logic [7:0]  send_q;
	logic        commit_q;
	logic [2:0]  outcome_q;
	logic signed [32:0] tdiff_q, span_q;
	logic signed [16:0] adiff_q;
	logic signed [49:0] prod_q;

	logic        cmd_hit, send_hit;
	logic [2:0]  dec_outcome;
	logic [31:0] fixed;
	logic [15:0] be16;
	logic [DivNumW-1:0] num_mag, quo;
	logic [DivDenW-1:0] den_mag;
	logic signed [49:0] prod_abs;
	logic signed [32:0] span_abs;
	logic signed [49:0] qs, v;
	logic        div_done;

	// Identifier matching against the two bases
	assign cmd_hit  = {1'b0, fid_q} == 12'(COMMAND_BASE) + {4'b0, node_q};
	assign send_hit = {1'b0, fid_q} == 12'(SEND_BASE) + {4'b0, node_q};
	assign be16     = {word_q[7:0], word_q[15:8]};

	// IEEE single to signed fixed point, truncating and saturating
	always_comb begin
		logic              sgn;
		logic [7:0]        e;
		logic [23:0]       mant;
		logic signed [9:0] sh;
		logic [33:0]       mag;
		logic [9:0]        nsh;
		sgn  = word_q[31];
		e    = word_q[30:23];
		mant = (e == 8'd0) ? {1'b0, word_q[22:0]} : {1'b1, word_q[22:0]};
		sh   = (e == 8'd0) ? 10'(FRAC_BITS - 149) : $signed({2'b0, e}) - 10'sd150 + 10'(FRAC_BITS);
		nsh  = 10'(-sh);
		mag  = '0;
		if (sh >= 10'sd9) begin
			mag = 34'd1 << 33;
		end else if (sh >= 10'sd0) begin
			mag = {10'b0, mant} << sh[3:0];
		end else if (sh > -10'sd32) begin
			mag = {10'b0, mant >> nsh[4:0]};
		end
		if (e == 8'hFF) begin
			fixed = (word_q[22:0] != 23'd0) ? 32'd0 : (sgn ? 32'h8000_0000 : 32'h7FFF_FFFF);
		end else if (sgn) begin
			fixed = (mag > 34'h0_8000_0000) ? 32'h8000_0000 : 32'(-mag);
		end else begin
			fixed = (mag > 34'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
		end
	end

	// Outcome of a frame that needs no mapping
	always_comb begin
		dec_outcome = OUT_IGNORED;
		if (cmd_hit) begin
			unique case (cmd_q)
				CMD_NODE_ID, CMD_WORD0, CMD_WORD1, CMD_WORD2, CMD_ADC_LO, CMD_ADC_HI,
				CMD_ANG_LO, CMD_ANG_HI, CMD_WORD3, CMD_WORD4, CMD_WORD5, CMD_WORD6,
				CMD_BYTE7: dec_outcome = OUT_SETTING;
				default:   dec_outcome = OUT_IGNORED;
			endcase
		end else if (send_hit) begin
			dec_outcome = OUT_SEND;
		end
	end

	// Divider operands as magnitudes
	assign prod_abs = prod_q[49] ? -prod_q : prod_q;
	assign span_abs = span_q[32] ? -span_q : span_q;
	assign num_mag  = prod_abs[DivNumW-1:0];
	assign den_mag  = span_abs[DivDenW-1:0];

	csd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num_mag),
		.den    (den_mag),
		.done   (div_done),
		.quo    (quo)
	);

	// Signed quotient, offset and clamp to the ADC range
	always_comb begin
		logic signed [49:0] alo_s, ahi_s;
		alo_s = $signed({34'b0, alo_q});
		ahi_s = $signed({34'b0, ahi_q});
		qs = (prod_q[49] ^ span_q[32]) ? -$signed({2'b0, quo}) : $signed({2'b0, quo});
		v  = qs + alo_s;
		if (v >= ahi_s) v = ahi_s;
		if (v <= alo_s) v = alo_s;
	end

	// Request latch and mapping operands
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			fid_q  <= frame_id;
			cmd_q  <= command;
			word_q <= word;
		end
		if (cmd.load_sub) begin
			tdiff_q <= $signed({fixed[31], fixed}) - $signed({anglo_q[31], anglo_q});
			adiff_q <= $signed({1'b0, ahi_q}) - $signed({1'b0, alo_q});
			span_q  <= $signed({anghi_q[31], anghi_q}) - $signed({anglo_q[31], anglo_q});
		end
		if (cmd.load_mul) begin
			prod_q <= tdiff_q * adiff_q;
		end
	end

	// Stored settings and result state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q    <= 8'(DEFAULT_NODE);
			alo_q     <= 16'd0;
			ahi_q     <= 16'd4095;
			anglo_q   <= 32'd0;
			anghi_q   <= AngHiRst;
			setp_q    <= 16'd0;
			send_q    <= 8'd0;
			commit_q  <= 1'b0;
			outcome_q <= OUT_IGNORED;
		end else begin
			if (cmd.apply_dec) begin
				outcome_q <= dec_outcome;
				if (dec_outcome == OUT_SETTING) commit_q <= 1'b1;
				if (dec_outcome == OUT_SEND) send_q <= cmd_q;
				if (cmd_hit) begin
					unique case (cmd_q)
						CMD_NODE_ID: node_q  <= word_q[7:0];
						CMD_ADC_LO:  alo_q   <= be16;
						CMD_ADC_HI:  ahi_q   <= be16;
						CMD_ANG_LO:  anglo_q <= fixed;
						CMD_ANG_HI:  anghi_q <= fixed;
						default:     ;
					endcase
				end
			end
			if (cmd.apply_zero) outcome_q <= OUT_ZERO;
			if (cmd.apply_map) begin
				outcome_q <= OUT_SETPOINT;
				setp_q    <= v[15:0];
			end
		end
	end

	assign sts.is_map    = cmd_hit && (cmd_q == CMD_TARGET);
	assign sts.span_zero = span_q == 33'sd0;
	assign sts.div_done  = div_done;

	assign outcome        = outcome_q;
	assign setpoint       = setp_q;
	assign send_code      = send_q;
	assign commit_pending = commit_q;
	assign node_address   = node_q;

endmodule

FILE: src/csd_ctrl.sv
// Controller state machine sequencing decode, mapping and result hand-off.
module csd_ctrl
	import csd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	output logic     m_tvalid,
	input  logic     m_tready,
	input  csd_sts_t sts,
	output csd_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DEC  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_DST  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_FIN  = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0] state_q, state_d;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.latch = s_tvalid;
				if (s_tvalid) state_d = ST_DEC;
			end
			ST_DEC: begin
				if (sts.is_map) begin
					cmd.load_sub = 1'b1;
					state_d      = ST_MUL;
				end else begin
					cmd.apply_dec = 1'b1;
					state_d       = ST_OUT;
				end
			end
			ST_MUL: begin
				if (sts.span_zero) begin
					cmd.apply_zero = 1'b1;
					state_d        = ST_OUT;
				end else begin
					cmd.load_mul = 1'b1;
					state_d      = ST_DST;
				end
			end
			ST_DST: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_done) state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.apply_map = 1'b1;
				state_d       = ST_OUT;
			end
			ST_OUT: begin
				if (m_tready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	assign s_tready = state_q == ST_IDLE;
	assign m_tvalid = state_q == ST_OUT;

endmodule

FILE: src/csd_chk.sv
// Port-level checker of the CAN servo command decoder and its binding.
module csd_chk
	import csd_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic [InDataW-1:0]  s_tdata,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [OutDataW-1:0] m_tdata
);

	// A pending result stays offered until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped before it was taken");

	// Only one request is in flight
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("request accepted while a result waits");

	// No result in the cycle after a request is accepted
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !m_tvalid)
		else $error("result appeared too early");

	// Once a result is taken the block is free again
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |=> s_tready)
		else $error("block not ready after result taken");

	// Outcome code stays within its defined set
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[2:0] <= OUT_ZERO))
		else $error("undefined outcome code");

endmodule

bind can_servo_command_decoder csd_chk u_csd_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
